// File: rtl/fis_pkg.sv
// Shared types and constants for the frequency inversion scrambler.
// Holds the carrier quarter-wave table, step decode and register codes.
// No dependencies.
package fis_pkg;

    localparam int     F0           = 3300;
    localparam int     FS           = 16000;
    localparam int     ANGLE_STEPS  = 160;
    localparam int     HALF_STEPS   = ANGLE_STEPS / 2;
    localparam int     QUARTER      = ANGLE_STEPS / 4;
    localparam int     CARRIER_STEP = (F0 * ANGLE_STEPS) / FS;
    localparam longint PI_Q30       = 64'sd3373259426;

    // Configuration register indexes
    localparam logic REG_PATH_SELECT = 1'b0;
    localparam logic REG_OUT_SHIFT   = 1'b1;

    localparam logic [1:0] PATH_SELECT_RESET = 2'd3;
    localparam logic [4:0] OUT_SHIFT_RESET   = 5'd15;

    // Delay line and phase selectors
    localparam logic [1:0] LINE_FIRST   = 2'd0;
    localparam logic [1:0] LINE_SECOND  = 2'd1;
    localparam logic [1:0] LINE_THIRD   = 2'd2;
    localparam logic       PHASE_FIRST  = 1'b0;
    localparam logic       PHASE_SECOND = 1'b1;

    // Work steps: scramble chain, then full chain
    localparam logic [2:0] STEP_SCR_FIR1  = 3'd0;
    localparam logic [2:0] STEP_SCR_MOD1  = 3'd1;
    localparam logic [2:0] STEP_SCR_FIR2  = 3'd2;
    localparam logic [2:0] STEP_FULL_FIR1 = 3'd3;
    localparam logic [2:0] STEP_FULL_MOD1 = 3'd4;
    localparam logic [2:0] STEP_FULL_FIR2 = 3'd5;
    localparam logic [2:0] STEP_FULL_MOD2 = 3'd6;
    localparam logic [2:0] STEP_FULL_FIR3 = 3'd7;

    typedef struct packed {
        logic       is_mod;
        logic [1:0] line;
        logic       phase_sel;
    } step_ctl_t;

    typedef logic [QUARTER:0][16:0] carrier_tab_t;

    // Shift-and-subtract quotient of two non-negative values; elaboration only
    function automatic longint uquot(input longint num, input longint den);
        longint rem;
        longint quo;
        rem = 0;
        quo = 0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            quo = quo <<< 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'sd1;
            end
        end
        return quo;
    endfunction

    // round(cos(2*pi*k/160) * 32768), Taylor series in Q30; elaboration only
    function automatic logic [16:0] carrier_mag(input int k);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint mag;
        x    = uquot(2 * PI_Q30 * longint'(k), longint'(ANGLE_STEPS));
        x2   = (x * x) >>> 30;
        term = 64'sd1 <<< 30;
        sum  = term;
        for (int i = 1; i <= 9; i++)
        begin
            term = uquot((term * x2) >>> 30, longint'((2 * i - 1) * (2 * i)));
            if ((i & 1) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (sum < 0)
            sum = 0;
        mag = (sum + 64'sd16384) >>> 15;
        return 17'(mag);
    endfunction

    function automatic carrier_tab_t build_carrier_tab();
        carrier_tab_t tab;
        for (int k = 0; k <= QUARTER; k++)
        begin
            tab[k] = carrier_mag(k);
        end
        return tab;
    endfunction

    localparam carrier_tab_t CARRIER_TAB = build_carrier_tab();

    // Signed Q15 carrier for an angle index 0..159, folded onto a quarter wave
    function automatic logic signed [16:0] carrier_lookup(input logic [7:0] angle);
        logic [7:0]  a;
        logic        neg;
        logic [16:0] mag;
        a   = angle;
        neg = 1'b0;
        if (a > 8'(HALF_STEPS))
            a = 8'(ANGLE_STEPS) - a;
        if (a > 8'(QUARTER))
        begin
            a   = 8'(HALF_STEPS) - a;
            neg = 1'b1;
        end
        mag = CARRIER_TAB[a[5:0]];
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic step_ctl_t step_decode(input logic [2:0] step);
        step_ctl_t ctl;
        unique case (step)
            STEP_SCR_FIR1:  ctl = '{1'b0, LINE_FIRST,  PHASE_FIRST};
            STEP_SCR_MOD1:  ctl = '{1'b1, LINE_FIRST,  PHASE_FIRST};
            STEP_SCR_FIR2:  ctl = '{1'b0, LINE_SECOND, PHASE_FIRST};
            STEP_FULL_FIR1: ctl = '{1'b0, LINE_FIRST,  PHASE_FIRST};
            STEP_FULL_MOD1: ctl = '{1'b1, LINE_FIRST,  PHASE_FIRST};
            STEP_FULL_FIR2: ctl = '{1'b0, LINE_SECOND, PHASE_FIRST};
            STEP_FULL_MOD2: ctl = '{1'b1, LINE_SECOND, PHASE_SECOND};
            STEP_FULL_FIR3: ctl = '{1'b0, LINE_THIRD,  PHASE_FIRST};
            default:        ctl = '{1'b0, LINE_FIRST,  PHASE_FIRST};
        endcase
        return ctl;
    endfunction

endpackage

// File: rtl/frequency_inversion_scrambler.sv
// Frequency inversion voice scrambler, top level.
// Depends on fis_pkg (carrier table, step decode) and fis_ram (line/coef storage).
//
// Usage:
//   Input channel (in_valid/in_ready): mode 0 transfers one audio sample,
//   mode 1 transfers one filter coefficient (coef_index, coef_value). A
//   coefficient transfer finishes in its own cycle and gives no result.
//   Output channel (out_valid/out_ready): one sample_out per mode-0 transfer.
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 path_select,
//   index 1 out_shift. Write it only while the block is idle.
// Timing:
//   One shared 17x17 multiplier with an accumulator walks every filter one
//   tap per cycle. A sample takes F filter passes and M modulations from
//   transfer in to result, with (F,M) = (0,0), (2,1), (3,2), (5,3) for
//   path_select 0..3. in_ready is high only while idle; one item is in
//   work at a time.
// Reset: delay lines read as zero (per-line fill count), phases zero,
//   path_select 3, out_shift 15. No clearing pass.
// Stall: a finished result sits in the output register; the next input can
//   transfer in while it waits, and a following result holds in FINISH until
//   the output register frees.
module frequency_inversion_scrambler
    import fis_pkg::*;
#(
    parameter int TAPS         = 64,
    parameter int PHASE_PERIOD = 160
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic signed [15:0] sample_in,
    input  logic [5:0]         coef_index,
    input  logic signed [15:0] coef_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample_out
);

    localparam int LAW   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FW    = $clog2(TAPS + 1);
    localparam int PHW   = (PHASE_PERIOD > 1) ? $clog2(PHASE_PERIOD) : 1;
    localparam int ACC_W = 34 + LAW;
    localparam int CIW   = (LAW > 6) ? LAW : 6;

    localparam logic [LAW-1:0] LAST_ADDR  = LAW'(TAPS - 1);
    localparam logic [FW-1:0]  FULL_FILL  = FW'(TAPS);
    localparam logic [PHW-1:0] LAST_PHASE = PHW'(PHASE_PERIOD - 1);

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-32768);
    localparam logic signed [33:0]      PRD_MAX = 34'sd32767;
    localparam logic signed [33:0]      PRD_MIN = -34'sd32768;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_PUSH     = 8'b0000_0010,
        S_MAC      = 8'b0000_0100,
        S_DRAIN    = 8'b0000_1000,
        S_MOD_LOOK = 8'b0001_0000,
        S_MOD_MUL  = 8'b0010_0000,
        S_MOD_OUT  = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    // Control state
    state_t             state_reg, state_next;
    logic [2:0]         step_reg, step_next;
    logic [1:0]         path_reg, path_next;
    logic [4:0]         shift_reg, shift_next;
    logic [LAW-1:0]     head_reg [3];
    logic [LAW-1:0]     head_next [3];
    logic [FW-1:0]      fill_reg [3];
    logic [FW-1:0]      fill_next [3];
    logic [PHW-1:0]     phase_reg [2];
    logic [PHW-1:0]     phase_next [2];
    logic [7:0]         angle_reg [2];
    logic [7:0]         angle_next [2];
    logic [LAW-1:0]     tap_reg, tap_next;
    logic               iss_reg, iss_next;
    logic               prod_v_reg, prod_v_next;
    logic               out_valid_reg, out_valid_next;

    // Datapath
    logic [LAW-1:0]          rd_addr_reg, rd_addr_next;
    logic                    live_reg, live_next;
    logic signed [15:0]      x_reg, x_next;
    logic signed [15:0]      sample_out_reg, sample_out_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [33:0]      prod_reg, prod_next;
    logic signed [16:0]      carrier_reg, carrier_next;

    // Storage ports
    logic [2:0]     line_we;
    logic [15:0]    line_rdata [3];
    logic [15:0]    coef_rdata;
    logic           coef_we;
    logic [CIW-1:0] coef_idx_ext;

    // Helpers
    step_ctl_t               ctl, adv_ctl, start_ctl;
    logic                    adv_done, start_done;
    logic [2:0]              adv_step, start_step;
    state_t                  adv_state;
    logic [LAW-1:0]          head_cur, head_dec, rd_addr_inc;
    logic [FW-1:0]           fill_cur;
    logic [15:0]             line_sel_data;
    logic signed [16:0]      mul_a, mul_b;
    logic signed [33:0]      mul_p;
    logic signed [ACC_W-1:0] fir_sh;
    logic signed [15:0]      fir_y;
    logic signed [33:0]      mod_round, mod_q;
    logic signed [15:0]      mod_y;
    logic [PHW-1:0]          phase_cur;
    logic [7:0]              angle_cur;
    logic [8:0]              angle_sum;
    logic [7:0]              angle_adv;
    logic                    in_xfer;

    assign ctl       = step_decode(step_reg);
    assign in_xfer   = in_valid && (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign sample_out = sample_out_reg;

    // ---------------------------------------------------------------
    // Storage: three delay lines as circular buffers, one coefficient RAM
    // ---------------------------------------------------------------
    assign head_cur    = head_reg[ctl.line];
    assign fill_cur    = fill_reg[ctl.line];
    assign head_dec    = (head_cur == '0) ? LAST_ADDR : head_cur - 1'b1;
    assign rd_addr_inc = (rd_addr_reg == LAST_ADDR) ? '0 : rd_addr_reg + 1'b1;

    for (genvar g = 0; g < 3; g++)
    begin : g_line
        fis_ram #(
            .WIDTH(16),
            .DEPTH(TAPS)
        ) u_line (
            .clk  (clk),
            .we   (line_we[g]),
            .waddr(head_dec),
            .wdata(x_reg),
            .raddr(rd_addr_reg),
            .rdata(line_rdata[g])
        );
    end

    // Out-of-range indexes are dropped
    assign coef_idx_ext = CIW'(coef_index);
    assign coef_we      = in_xfer && mode && (32'(coef_index) < TAPS);

    fis_ram #(
        .WIDTH(16),
        .DEPTH(TAPS)
    ) u_coef (
        .clk  (clk),
        .we   (coef_we),
        .waddr(coef_idx_ext[LAW-1:0]),
        .wdata(coef_value),
        .raddr(tap_reg),
        .rdata(coef_rdata)
    );

    assign line_sel_data = line_rdata[ctl.line];

    // ---------------------------------------------------------------
    // Shared multiplier: taps x coefficients, or sample x carrier
    // ---------------------------------------------------------------
    always_comb
    begin
        if (state_reg == S_MOD_MUL)
        begin
            mul_a = 17'(x_reg);
            mul_b = carrier_reg;
        end
        else
        begin
            // entries past the fill count read as zero
            mul_a = live_reg ? 17'($signed(line_sel_data)) : '0;
            mul_b = 17'($signed(coef_rdata));
        end
    end

    assign mul_p = mul_a * mul_b;

    // FIR output: floor shift, saturate
    assign fir_sh = acc_reg >>> shift_reg;
    assign fir_y  = (fir_sh > ACC_MAX) ? 16'sh7FFF :
                    (fir_sh < ACC_MIN) ? 16'sh8000 : fir_sh[15:0];

    // Modulator output: divide by 2^14 toward zero, saturate
    assign mod_round = prod_reg + (prod_reg[33] ? 34'sd16383 : 34'sd0);
    assign mod_q     = mod_round >>> 14;
    assign mod_y     = (mod_q > PRD_MAX) ? 16'sh7FFF :
                       (mod_q < PRD_MIN) ? 16'sh8000 : mod_q[15:0];

    // Phase and carrier angle advance together; angle = 33*phase mod 160
    assign phase_cur = phase_reg[ctl.phase_sel];
    assign angle_cur = angle_reg[ctl.phase_sel];
    assign angle_sum = {1'b0, angle_cur} + 9'(CARRIER_STEP);
    assign angle_adv = (angle_sum >= 9'(ANGLE_STEPS)) ?
                       8'(angle_sum - 9'(ANGLE_STEPS)) : angle_sum[7:0];

    // ---------------------------------------------------------------
    // Step sequencing
    // ---------------------------------------------------------------
    always_comb
    begin
        if (step_reg == STEP_FULL_FIR3 || (step_reg == STEP_SCR_FIR2 && !path_reg[1]))
        begin
            adv_done = 1'b1;
            adv_step = step_reg;
        end
        else
        begin
            adv_done = 1'b0;
            adv_step = step_reg + 3'd1;
        end
    end

    assign adv_ctl    = step_decode(adv_step);
    assign adv_state  = adv_done ? S_FINISH : (adv_ctl.is_mod ? S_MOD_LOOK : S_PUSH);
    assign start_done = (path_reg == 2'd0);
    assign start_step = path_reg[0] ? STEP_SCR_FIR1 : STEP_FULL_FIR1;
    assign start_ctl  = step_decode(start_step);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        path_next       = path_reg;
        shift_next      = shift_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        phase_next      = phase_reg;
        angle_next      = angle_reg;
        tap_next        = tap_reg;
        rd_addr_next    = rd_addr_reg;
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        x_next          = x_reg;
        carrier_next    = carrier_reg;
        line_we         = 3'b000;
        iss_next        = 1'b0;
        live_next       = 1'b0;
        prod_next       = mul_p;
        prod_v_next     = iss_reg;
        acc_next        = prod_v_reg ? acc_reg + ACC_W'(prod_reg) : acc_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PATH_SELECT: path_next  = cfg_data[1:0];
                REG_OUT_SHIFT:   shift_next = cfg_data;
                default:         path_next  = path_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !mode)
                begin
                    x_next = sample_in;
                    if (start_done)
                        state_next = S_FINISH;
                    else
                    begin
                        step_next  = start_step;
                        state_next = start_ctl.is_mod ? S_MOD_LOOK : S_PUSH;
                    end
                end
            end
            S_PUSH:
            begin
                // newest sample goes one slot below the old head
                line_we[ctl.line]   = 1'b1;
                head_next[ctl.line] = head_dec;
                fill_next[ctl.line] = (fill_cur == FULL_FILL) ? fill_cur : fill_cur + 1'b1;
                rd_addr_next        = head_dec;
                tap_next            = '0;
                acc_next            = '0;
                state_next          = S_MAC;
            end
            S_MAC:
            begin
                iss_next     = 1'b1;
                live_next    = (FW'(tap_reg) < fill_cur);
                rd_addr_next = rd_addr_inc;
                tap_next     = tap_reg + 1'b1;
                if (tap_reg == LAST_ADDR)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // read and multiply stages empty: accumulator is final
                if (!iss_reg && !prod_v_reg)
                begin
                    x_next     = fir_y;
                    step_next  = adv_done ? step_reg : adv_step;
                    state_next = adv_state;
                end
            end
            S_MOD_LOOK:
            begin
                carrier_next = carrier_lookup(angle_cur);
                state_next   = S_MOD_MUL;
            end
            S_MOD_MUL:
            begin
                state_next = S_MOD_OUT;
            end
            S_MOD_OUT:
            begin
                x_next = mod_y;
                if (phase_cur == LAST_PHASE)
                begin
                    phase_next[ctl.phase_sel] = '0;
                    angle_next[ctl.phase_sel] = '0;
                end
                else
                begin
                    phase_next[ctl.phase_sel] = phase_cur + 1'b1;
                    angle_next[ctl.phase_sel] = angle_adv;
                end
                step_next  = adv_done ? step_reg : adv_step;
                state_next = adv_state;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = x_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_SCR_FIR1;
            path_reg      <= PATH_SELECT_RESET;
            shift_reg     <= OUT_SHIFT_RESET;
            tap_reg       <= '0;
            iss_reg       <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++)
            begin
                phase_reg[i] <= '0;
                angle_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            path_reg      <= path_next;
            shift_reg     <= shift_next;
            tap_reg       <= tap_next;
            iss_reg       <= iss_next;
            prod_v_reg    <= prod_v_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            angle_reg     <= angle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg    <= rd_addr_next;
        live_reg       <= live_next;
        x_reg          <= x_next;
        acc_reg        <= acc_next;
        prod_reg       <= prod_next;
        carrier_reg    <= carrier_next;
        sample_out_reg <= sample_out_next;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg[0] <= FULL_FILL) && (fill_reg[1] <= FULL_FILL) && (fill_reg[2] <= FULL_FILL))
        else $error("delay line fill count beyond tap count");

    a_angle_sync: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg[0] != '0) || (angle_reg[0] == '0)) &&
        ((phase_reg[1] != '0) || (angle_reg[1] == '0)))
        else $error("carrier angle not zero at phase zero");

    a_mac_confined: assert property (@(posedge clk) disable iff (!rst_n)
        prod_v_reg |-> (state_reg == S_MAC || state_reg == S_DRAIN))
        else $error("product pending outside a filter pass");

    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !mode) |=> (state_reg != S_IDLE))
        else $error("sample transfer did not start work");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && !out_ready) |=> (state_reg == S_FINISH))
        else $error("result left FINISH over an untaken output");

endmodule

// File: rtl/fis_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the delay lines and the coefficient store. No dependencies.
module fis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: verif/tb_frequency_inversion_scrambler.sv
// Self-checking testbench for frequency_inversion_scrambler (FIR / carrier / FIR chains).
// Needs rtl/fis_pkg.sv (register codes, reset values) and the scrambler RTL.
// Built-in bit-exact predictor; random handshake pressure on both channels.
module tb_frequency_inversion_scrambler;
    import fis_pkg::*;

    // Block geometry and carrier constants (16 kHz audio, 3.3 kHz carrier)
    localparam int     TAPS         = 64;
    localparam int     PHASE_WRAP   = 160;
    localparam int     TONE_HZ      = 3300;
    localparam int     RATE_HZ      = 16000;
    localparam int     TURN_STEPS   = 160;
    localparam int     TONE_STEP    = (TONE_HZ * TURN_STEPS) / RATE_HZ;
    localparam longint PI_FIX30     = 64'sd3373259426;

    // Input item kinds
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    // path_select codes
    localparam logic [1:0] PATH_NONE     = 2'd0;
    localparam logic [1:0] PATH_SCRAMBLE = 2'd1;
    localparam logic [1:0] PATH_FULL     = 2'd2;
    localparam logic [1:0] PATH_BOTH     = 2'd3;

    localparam logic [4:0] SHIFT_MIN = 5'd0;
    localparam logic [4:0] SHIFT_MAX = 5'd31;

    // Coefficient set flavors
    localparam int COEF_EDGE   = 0;
    localparam int COEF_SMALL  = 1;
    localparam int COEF_FULL   = 2;
    localparam int COEF_SPARSE = 3;

    // Settle time covers the worst sample (both chains) with a little margin
    localparam int SETTLE_CYCLES = 420;
    localparam int FINAL_WAIT    = 20000;
    localparam int CYCLE_LIMIT   = 3000000;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_valid  = 1'b0;
    logic               cfg_ready;
    logic [0:0]         cfg_index  = '0;
    logic [4:0]         cfg_data   = '0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic               mode       = MODE_SAMPLE;
    logic signed [15:0] sample_in  = '0;
    logic [5:0]         coef_index = '0;
    logic signed [15:0] coef_value = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic signed [15:0] sample_out;

    // Predictor state, mirrors what the block holds
    logic signed [15:0] delay_lines [3][TAPS];
    logic signed [15:0] coef_mem [TAPS];
    int                 phase_count [2];
    logic [1:0]         path_sel  = PATH_SELECT_RESET;
    logic [4:0]         shift_amt = OUT_SHIFT_RESET;

    logic signed [15:0] expected_samples [$];
    logic signed [15:0] want_sample;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int mismatch_count = 0;
    int samples_sent   = 0;
    int coefs_sent     = 0;
    int results_seen   = 0;
    int config_writes  = 0;

    frequency_inversion_scrambler dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .sample_in  (sample_in),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run guard: a hung block ends the run here
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding",
                     cycle_count, expected_samples.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver backpressure; stall rate set per phase
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR cycle %0d: %s (got %0d, expected %0d)", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // -------------------------------------------------------------------
    // Predictor
    // -------------------------------------------------------------------
    function automatic int clamp16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return int'(v);
    endfunction

    // round(cos(2*pi*angle/160) * 32768), Taylor series in Q30 on one quarter wave
    function automatic int cosine_q15(input int angle);
        int     a;
        bit     neg;
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint mag;
        a   = angle % TURN_STEPS;
        neg = 1'b0;
        if (a > TURN_STEPS / 2)
            a = TURN_STEPS - a;
        if (a > TURN_STEPS / 4)
        begin
            a   = TURN_STEPS / 2 - a;
            neg = 1'b1;
        end
        x    = (2 * PI_FIX30 * longint'(a)) / TURN_STEPS;
        x2   = (x * x) >>> 30;
        term = 64'sd1 <<< 30;
        sum  = term;
        for (int i = 1; i <= 9; i++)
        begin
            term = ((term * x2) >>> 30) / longint'((2 * i - 1) * (2 * i));
            sum  = (i % 2 == 1) ? sum - term : sum + term;
        end
        if (sum < 0)
            sum = 0;
        mag = (sum + 64'sd16384) >>> 15;
        return neg ? -int'(mag) : int'(mag);
    endfunction

    // Newest sample enters at tap 0; floor shift, then saturate
    function automatic int run_fir(input int line_id, input int x);
        longint acc;
        for (int j = TAPS - 1; j > 0; j--)
            delay_lines[line_id][j] = delay_lines[line_id][j - 1];
        delay_lines[line_id][0] = 16'(x);
        acc = 0;
        for (int j = 0; j < TAPS; j++)
            acc += longint'(delay_lines[line_id][j]) * longint'(coef_mem[j]);
        return clamp16(acc >>> shift_amt);
    endfunction

    // x * carrier / 2^14, truncated toward zero; phase steps after use
    function automatic int modulate_carrier(input int x, input int pid);
        int     angle;
        longint prod;
        angle = (phase_count[pid] * TONE_STEP) % TURN_STEPS;
        prod  = longint'(x) * longint'(cosine_q15(angle));
        phase_count[pid] = (phase_count[pid] + 1) % PHASE_WRAP;
        return clamp16(prod / 64'sd16384);
    endfunction

    // Both chains share line 0/1 and the first phase when both are on
    function automatic logic signed [15:0] scramble_sample(input logic signed [15:0] s);
        int x;
        x = s;
        if (path_sel[0])
        begin
            x = run_fir(0, x);
            x = modulate_carrier(x, 0);
            x = run_fir(1, x);
        end
        if (path_sel[1])
        begin
            x = run_fir(0, x);
            x = modulate_carrier(x, 0);
            x = run_fir(1, x);
            x = modulate_carrier(x, 1);
            x = run_fir(2, x);
        end
        return 16'(x);
    endfunction

    // -------------------------------------------------------------------
    // Result checker: ready/valid are stable by the falling edge, so the
    // transfer seen here is the one taken at the next rising edge.
    // -------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
                report_mismatch("sample_out with no pending sample", sample_out, 0);
            else
            begin
                want_sample = expected_samples.pop_front();
                if (sample_out !== want_sample)
                    report_mismatch("sample_out", sample_out, want_sample);
                results_seen++;
            end
        end
    end

    // -------------------------------------------------------------------
    // Drivers. All called right after a rising edge.
    // -------------------------------------------------------------------
    task automatic send_item(input logic item_mode, input logic signed [15:0] smp,
                             input logic [5:0] cidx, input logic signed [15:0] cval);
        bit taken;
        // Optional idle gap; valid drops only when a gap really happens
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        mode       <= item_mode;
        sample_in  <= smp;
        coef_index <= cidx;
        coef_value <= cval;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        // Transfer just happened at this edge
        if (item_mode == MODE_COEF)
        begin
            coef_mem[cidx] = cval;
            coefs_sent++;
        end
        else
        begin
            expected_samples.push_back(scramble_sample(smp));
            samples_sent++;
        end
    endtask

    task automatic write_register(input logic [0:0] idx, input logic [4:0] data);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == REG_PATH_SELECT)
            path_sel = data[1:0];
        else
            shift_amt = data;
        config_writes++;
        @(posedge clk);
    endtask

    // Upper data bits of path_select are junk the block must drop
    task automatic configure(input logic [1:0] path, input logic [4:0] shift);
        write_register(REG_PATH_SELECT, {3'($urandom_range(7)), path});
        write_register(REG_OUT_SHIFT, shift);
    endtask

    // Stop sending, collect every result, then let the block go fully idle
    task automatic settle_block();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_sample();
        int sel;
        sel = $urandom_range(19);
        if (sel < 13)
            return 16'($urandom);
        if (sel < 17)
            return 16'(int'($urandom_range(512)) - 256);
        case (sel)
            17:      return 16'sh7FFF;
            18:      return 16'sh8000;
            default: return 16'sh0000;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_coef(input int style, input int j);
        case (style)
            COEF_EDGE:
            begin
                if (j == 0)
                    return 16'sh7FFF;
                if (j == TAPS - 1)
                    return 16'sh8000;
                return 16'(int'($urandom_range(512)) - 256);
            end
            COEF_SMALL:  return 16'(int'($urandom_range(4096)) - 2048);
            COEF_SPARSE: return ($urandom_range(7) == 0) ? 16'($urandom) : 16'sh0000;
            default:     return 16'($urandom);
        endcase
    endfunction

    // Every entry is written so no unwritten coefficient is ever read
    task automatic load_coefficients(input int style);
        for (int j = 0; j < TAPS; j++)
            send_item(MODE_COEF, 16'($urandom), 6'(j), pick_coef(style, j));
    endtask

    // -------------------------------------------------------------------
    // Tests
    // -------------------------------------------------------------------
    task automatic test_coefficient_load();
        // Full-scale positive at tap 0, full-scale negative at the last tap
        load_coefficients(COEF_EDGE);
    endtask

    task automatic test_reset_settings();
        // Registers still at reset: both chains, shift 15
        send_item(MODE_SAMPLE, 16'sh7FFF, 6'($urandom), 16'($urandom));
        send_item(MODE_SAMPLE, 16'sh8000, 6'($urandom), 16'($urandom));
        send_item(MODE_SAMPLE, 16'sh0000, 6'($urandom), 16'($urandom));
        send_item(MODE_SAMPLE, 16'shFFFF, 6'($urandom), 16'($urandom));
        send_item(MODE_SAMPLE, 16'sh0001, 6'($urandom), 16'($urandom));
        send_item(MODE_SAMPLE, 16'sh7FFF, 6'($urandom), 16'($urandom));
        send_item(MODE_SAMPLE, 16'sh7FFF, 6'($urandom), 16'($urandom));
        send_item(MODE_SAMPLE, 16'sh8000, 6'($urandom), 16'($urandom));
    endtask

    // Each path code with both shift extremes; path none is a straight wire
    task automatic test_path_and_shift();
        for (int p = PATH_NONE; p <= PATH_BOTH; p++)
        begin
            settle_block();
            configure(2'(p), SHIFT_MIN);
            send_item(MODE_SAMPLE, 16'sh7FFF, 6'($urandom), 16'($urandom));
            send_item(MODE_SAMPLE, 16'sh8000, 6'($urandom), 16'($urandom));
            settle_block();
            configure(2'(p), SHIFT_MAX);
            send_item(MODE_SAMPLE, 16'sh8000, 6'($urandom), 16'($urandom));
            send_item(MODE_SAMPLE, pick_sample(), 6'($urandom), 16'($urandom));
        end
    endtask

    // One traffic phase: fresh coefficient set, then three register settings
    // with samples and the odd coefficient rewrite in between.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items, input int style);
        int per_setting;
        logic [4:0] shift;
        settle_block();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        load_coefficients(style);
        per_setting = (n_items - TAPS) / 3;
        for (int s = 0; s < 3; s++)
        begin
            settle_block();
            // Mostly mid-range shifts so outputs are not all saturated
            shift = $urandom_range(1) ? 5'($urandom_range(19, 11)) : 5'($urandom_range(31));
            configure(2'($urandom_range(3)), shift);
            for (int n = 0; n < per_setting; n++)
            begin
                if ($urandom_range(99) < 10)
                    send_item(MODE_COEF, 16'($urandom), 6'($urandom_range(TAPS - 1)),
                              pick_coef(style, int'($urandom_range(TAPS - 1))));
                else
                    send_item(MODE_SAMPLE, pick_sample(), 6'($urandom), 16'($urandom));
            end
        end
    endtask

    initial
    begin
        int waited;
        foreach (delay_lines[l, j])
            delay_lines[l][j] = '0;
        foreach (coef_mem[j])
            coef_mem[j] = '0;
        phase_count[0] = 0;
        phase_count[1] = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_coefficient_load();
        test_reset_settings();
        test_path_and_shift();
        // No idling, sender gaps, receiver stalls, then both at once
        test_random_traffic(0, 0, 265, COEF_SMALL);
        test_random_traffic(59, 0, 265, COEF_FULL);
        test_random_traffic(0, 59, 265, COEF_SPARSE);
        test_random_traffic(18, 18, 265, COEF_SMALL);

        in_valid <= 1'b0;
        waited = 0;
        while (expected_samples.size() != 0 && waited < FINAL_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_samples.size() != 0)
            report_mismatch("samples never returned", 0, expected_samples.size());
        // Tail: anything extra that still comes out is flagged by the checker
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d audio samples, %0d coefficient writes, %0d register writes",
                 samples_sent, coefs_sent, config_writes);
        $display("over all four path settings; %0d results checked, %0d mismatches",
                 results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
